### hdl/fed_pkg.sv
// Shared constants, codes and types of the feedforward echo delay block.
package fed_pkg;

  localparam int HISTORY_DEPTH = 65536;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

  localparam int SAMPLE_W = 32;
  localparam int DELAY_W  = 16;
  localparam int GAIN_W   = 17;
  localparam int FMT_W    = 2;
  localparam int SEEN_W   = 17;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // Wide enough for delay and history addresses, plus one bit for the wrap sum.
  localparam int CALC_W = ((HIST_AW > DELAY_W) ? HIST_AW : DELAY_W) + 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam logic [7:0]        U8_MID   = 8'd127;

  // Sample format codes. The unused code behaves as signed 32-bit.
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;

  // Register indexes.
  localparam logic [1:0] REG_DELAY  = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_FORMAT = 2'd2;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [GAIN_W-1:0]  gain;
    logic [FMT_W-1:0]   fmt;
  } fed_cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [FMT_W-1:0]    fmt;
    logic [GAIN_W-1:0]   gain;
    logic                pass;
    logic                fwd;
  } fed_item_t;

endpackage

### hdl/feedforward_echo_delay.sv
// Feedforward echo delay: y[n] = x[n] + trunc(decay * x[n-D]) over a sample stream.
// An accepted request is registered in stages 1, 2 and 3, then in the output register.
// Throughput: one sample per cycle if not stalled; history RAM written and read once per sample.
// A stalled output keeps accepting until the three internal stages and the output fill.
// Reset (synchronous, active high) clears the valid bits, write position, seen count and
// registers; the history RAM is not cleared and its entries are read only once written.
module feedforward_echo_delay (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fed_pkg::SAMPLE_W-1:0] s_tdata,  // [31:0] in_sample
  input  logic                        s_tuser,  // [0] stream_start
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fed_pkg::SAMPLE_W-1:0] m_tdata,  // [31:0] out_sample
  output logic                        m_tuser,  // [0] wrapped
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fed_pkg::APB_AW-1:0]  paddr,
  input  logic [fed_pkg::APB_DW-1:0]  pwdata,
  output logic [fed_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import fed_pkg::*;

  fed_cfg_t  cfg;
  fed_item_t item;

  logic                accept;
  logic [HIST_AW-1:0]  wp, wp_next;
  logic [SEEN_W-1:0]   seen, seen_eff, seen_next;
  logic [CALC_W-1:0]   d_ext, dcl, wp_ext, rd_ext;
  logic [GAIN_W-1:0]   gain_sat;
  logic [SAMPLE_W-1:0] rdata;

  assign accept = s_tvalid && s_tready;

  // Delay clamped to one less than the history depth; read address trails the write position.
  always_comb begin
    d_ext    = CALC_W'(cfg.delay);
    dcl      = (d_ext > CALC_W'(HISTORY_DEPTH - 1)) ? CALC_W'(HISTORY_DEPTH - 1) : d_ext;
    wp_ext   = CALC_W'(wp);
    rd_ext   = (wp_ext >= dcl) ? wp_ext - dcl : wp_ext + CALC_W'(HISTORY_DEPTH) - dcl;
    wp_next  = (wp == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
    seen_eff = s_tuser ? '0 : seen;
    seen_next = (seen_eff == SEEN_MAX) ? seen_eff : seen_eff + 1'b1;
    gain_sat = (cfg.gain > GAIN_ONE) ? GAIN_ONE : cfg.gain;

    item.sample = s_tdata;
    item.fmt    = cfg.fmt;
    item.gain   = gain_sat;
    item.pass   = CALC_W'(seen_eff) < dcl;
    // Zero delay reads the sample being written, which the RAM returns old; forward it.
    item.fwd    = (dcl == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      seen <= '0;
    end else if (accept) begin
      wp   <= wp_next;
      seen <= seen_next;
    end
  end

  fed_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fed_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (s_tdata),
    .ren   (accept),
    .raddr (rd_ext[HIST_AW-1:0]),
    .rdata (rdata)
  );

  fed_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (item),
    .rdata       (rdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_sample  (m_tdata),
    .out_wrapped (m_tuser)
  );

endmodule

### hdl/fed_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fed_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address written in the same cycle returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/fed_regs.sv
// Configuration registers behind the APB-style port.
module fed_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fed_pkg::APB_AW-1:0] paddr,
  input  logic [fed_pkg::APB_DW-1:0] pwdata,
  output logic [fed_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output fed_pkg::fed_cfg_t         cfg
);
  import fed_pkg::*;

  logic [1:0] index;
  logic       wr;

  assign pready = 1'b1;
  assign index  = paddr[APB_AW-1:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay <= '0;
      cfg.gain  <= '0;
      cfg.fmt   <= FMT_S16;
    end else if (wr) begin
      case (index)
        REG_DELAY:  cfg.delay <= pwdata[DELAY_W-1:0];
        REG_GAIN:   cfg.gain  <= pwdata[GAIN_W-1:0];
        REG_FORMAT: cfg.fmt   <= pwdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_DELAY:  prdata = APB_DW'(cfg.delay);
      REG_GAIN:   prdata = APB_DW'(cfg.gain);
      REG_FORMAT: prdata = APB_DW'(cfg.fmt);
      default:    prdata = '0;
    endcase
  end

endmodule

### hdl/fed_scale.sv
// Echo datapath: delayed-sample magnitude, gain multiply, wrapping add, output register.
module fed_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fed_pkg::fed_item_t          in_item,
  input  logic [fed_pkg::SAMPLE_W-1:0] rdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fed_pkg::SAMPLE_W-1:0] out_sample,
  output logic                        out_wrapped
);
  import fed_pkg::*;

  localparam int PROD_W = SAMPLE_W + GAIN_W;
  localparam int SUM_W  = SAMPLE_W + 2;

  logic v1, v2, v3;
  logic en1, en2, en3, eno;

  fed_item_t it1, it2, it3;
  logic                neg2, neg3;
  logic [SAMPLE_W-1:0] mag2, sc3;

  logic [SAMPLE_W-1:0] dv;
  logic                neg1;
  logic [SAMPLE_W-1:0] mag1;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    xv, sv, sum;
  logic [SAMPLE_W-1:0] res, xm;
  logic                wrap;

  // Each stage loads when it is empty or the stage after it is moving on.
  assign eno      = !out_valid || out_ready;
  assign en3      = !v3 || eno;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: sign and magnitude of the delayed sample under the current format.
  always_comb begin
    dv = it1.fwd ? it1.sample : rdata;
    case (it1.fmt)
      FMT_U8: begin
        neg1 = dv[7:0] < U8_MID;
        mag1 = neg1 ? SAMPLE_W'(U8_MID - dv[7:0]) : SAMPLE_W'(dv[7:0] - U8_MID);
      end
      FMT_S16: begin
        neg1 = dv[15];
        mag1 = neg1 ? SAMPLE_W'(16'(-dv[15:0])) : SAMPLE_W'(dv[15:0]);
      end
      default: begin
        neg1 = dv[31];
        mag1 = neg1 ? -dv : dv;
      end
    endcase
  end

  // Stage 2: Q1.16 scaling, truncated toward zero on the magnitude.
  assign prod = PROD_W'(mag2) * PROD_W'(it2.gain);

  // Stage 3: signed add with wrap detection at the sample width.
  always_comb begin
    case (it3.fmt)
      FMT_U8:  xv = SUM_W'(it3.sample[7:0]);
      FMT_S16: xv = {{(SUM_W-16){it3.sample[15]}}, it3.sample[15:0]};
      default: xv = {{(SUM_W-SAMPLE_W){it3.sample[SAMPLE_W-1]}}, it3.sample};
    endcase
    sv  = SUM_W'(sc3);
    sum = neg3 ? xv - sv : xv + sv;
    case (it3.fmt)
      FMT_U8: begin
        wrap = |sum[SUM_W-1:8];
        res  = SAMPLE_W'(sum[7:0]);
        xm   = SAMPLE_W'(it3.sample[7:0]);
      end
      FMT_S16: begin
        wrap = !((&sum[SUM_W-1:15]) || !(|sum[SUM_W-1:15]));
        res  = SAMPLE_W'(sum[15:0]);
        xm   = SAMPLE_W'(it3.sample[15:0]);
      end
      default: begin
        wrap = !((&sum[SUM_W-1:SAMPLE_W-1]) || !(|sum[SUM_W-1:SAMPLE_W-1]));
        res  = sum[SAMPLE_W-1:0];
        xm   = it3.sample;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (eno) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      it1 <= in_item;
    end
    if (en2) begin
      it2  <= it1;
      neg2 <= neg1;
      mag2 <= mag1;
    end
    if (en3) begin
      it3  <= it2;
      neg3 <= neg2;
      sc3  <= prod[SAMPLE_W+15:16];
    end
    if (eno) begin
      out_sample  <= it3.pass ? xm : res;
      out_wrapped <= it3.pass ? 1'b0 : wrap;
    end
  end

endmodule

### hdl/fed_checker.sv
// Port-level checks for the feedforward echo delay block, bound to its top level.
module fed_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [fed_pkg::SAMPLE_W-1:0] s_tdata,
  input logic                        s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [fed_pkg::SAMPLE_W-1:0] m_tdata,
  input logic                        m_tuser
);

  // A result waiting on the output holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // With the output free, the block always takes a new request.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input refused while the output was free");

  // A result after an idle output comes from a request carried unstalled through stages 1, 2 and 3.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && $past(!m_tvalid, 1) && $past(!m_tvalid, 2) && $past(!m_tvalid, 3)
      |-> $past(s_tvalid && s_tready, 4))
    else $error("result without a matching request");

endmodule

bind feedforward_echo_delay fed_checker u_fed_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### bench/fed_echo_checker.sv
// Scoreboard for the feedforward echo delay: predicts each result and compares it with the output.
module fed_echo_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [fed_pkg::SAMPLE_W-1:0] s_tdata,   // [31:0] in_sample
  input  logic                        s_tuser,   // [0] stream_start
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [fed_pkg::SAMPLE_W-1:0] m_tdata,   // [31:0] out_sample
  input  logic                        m_tuser,   // [0] wrapped
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fed_pkg::APB_AW-1:0]  paddr,
  input  logic [fed_pkg::APB_DW-1:0]  pwdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          pending
);
  import fed_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                wrapped;
  } echo_result_t;

  fed_cfg_t            cfg;
  logic [SAMPLE_W-1:0] history [HISTORY_DEPTH];
  logic [HIST_AW-1:0]  wr_pos;
  logic [SEEN_W-1:0]   seen;
  echo_result_t        echo_due [$];
  echo_result_t        due;

  function automatic echo_result_t echo_predict(input logic [SAMPLE_W-1:0] x,
                                                input logic               start);
    logic [GAIN_W-1:0]   g;
    logic [HIST_AW-1:0]  rd;
    logic [SAMPLE_W-1:0] dv;
    longint              xs, ds, scaled, sum, half;
    longint unsigned     mag, mask;
    int                  width;
    echo_result_t        r;
    g     = (cfg.gain > GAIN_ONE) ? GAIN_ONE : cfg.gain;
    width = (cfg.fmt == FMT_U8) ? 8 : ((cfg.fmt == FMT_S16) ? 16 : 32);
    mask  = (64'd1 << width) - 64'd1;
    if (start)
      seen = '0;
    history[wr_pos] = x;
    rd = wr_pos - HIST_AW'(cfg.delay);
    r.wrapped = 1'b0;
    if (seen < SEEN_W'(cfg.delay)) begin
      r.sample = SAMPLE_W'(x & mask);
    end else begin
      dv = history[rd];
      if (width == 8) begin
        // The delayed 8-bit sample acts as a signed offset from the midpoint.
        xs     = x[7:0];
        mag    = (dv[7:0] < U8_MID) ? U8_MID - dv[7:0] : dv[7:0] - U8_MID;
        scaled = (mag * g) >> 16;
        sum    = (dv[7:0] < U8_MID) ? xs - scaled : xs + scaled;
        r.wrapped = (sum < 0) || (sum > 255);
      end else begin
        half   = 64'sd1 <<< (width - 1);
        xs     = (width == 16) ? longint'($signed(x[15:0])) : longint'($signed(x));
        ds     = (width == 16) ? longint'($signed(dv[15:0])) : longint'($signed(dv));
        mag    = (ds < 0) ? -ds : ds;
        scaled = (mag * g) >> 16;
        sum    = (ds < 0) ? xs - scaled : xs + scaled;
        r.wrapped = (sum < -half) || (sum > half - 1);
      end
      r.sample = SAMPLE_W'(sum & mask);
    end
    wr_pos = wr_pos + 1'b1;
    if (seen != SEEN_MAX)
      seen = seen + 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg        = '{delay: '0, gain: '0, fmt: FMT_S16};
      wr_pos     = '0;
      seen       = '0;
      mismatches = 0;
      echo_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_DELAY:  cfg.delay = pwdata[DELAY_W-1:0];
          REG_GAIN:   cfg.gain  = pwdata[GAIN_W-1:0];
          REG_FORMAT: cfg.fmt   = pwdata[FMT_W-1:0];
          default: ;
        endcase
      end
      // Results are retired before the new request is queued, so a result
      // that overtakes its request is caught.
      if (m_tvalid && m_tready) begin
        if (echo_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got sample %h wrapped %0b",
                   $time, m_tdata, m_tuser);
        end else begin
          due = echo_due.pop_front();
          if (m_tdata !== due.sample || m_tuser !== due.wrapped) begin
            mismatches++;
            $display("%0t: result mismatch, expected sample %h wrapped %0b, got %h %0b",
                     $time, due.sample, due.wrapped, m_tdata, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready)
        echo_due.push_back(echo_predict(s_tdata, s_tuser));
    end
    pending = echo_due.size();
  end

endmodule

### bench/feedforward_echo_delay_tb.sv
// Top of the feedforward echo delay testbench: clock, reset, stimulus and verdict.
module feedforward_echo_delay_tb;
  import fed_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;
  logic                m_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int mismatches;
  int pending;
  int send_gap_pct = 34;
  int recv_gap_pct = 66;

  feedforward_echo_delay dut (.*);

  fed_echo_checker checker_i (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .pending
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic start);
    if ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
  endtask

  // Holds off new requests until every predicted result has been seen.
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // The bus returns to idle after each write before the next setup cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_echo(input logic [DELAY_W-1:0] delay, input logic [GAIN_W-1:0] gain,
                          input logic [FMT_W-1:0] fmt);
    drain();
    reg_write(REG_DELAY, APB_DW'(delay));
    reg_write(REG_GAIN, APB_DW'(gain));
    reg_write(REG_FORMAT, APB_DW'(fmt));
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] edges [8];
    edges = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h0000_7FFF, 32'hFFFF_8000, 32'h0000_007F, 32'hFFFF_FF80};
    if ($urandom_range(7) == 0)
      return edges[$urandom_range(7)];
    return $urandom();
  endfunction

  initial begin
    logic [DELAY_W-1:0] delay;
    logic [GAIN_W-1:0]  gain;
    logic [FMT_W-1:0]   fmt;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: no delay and zero gain, so samples come out masked.
    send_sample(32'hFFFF_8000, 1'b1);
    send_sample(32'h0001_7FFF, 1'b0);

    // Gain above one saturates; the sample echoed onto itself wraps both ways.
    set_echo('0, '1, FMT_S16);
    send_sample(32'h0000_7FFF, 1'b0);
    send_sample(32'h0000_8000, 1'b0);
    send_sample(32'h0000_0001, 1'b0);

    // Unsigned bytes around the midpoint; the first three pass through.
    set_echo(16'd3, GAIN_ONE, FMT_U8);
    send_sample(32'hFFFF_FF00, 1'b1);
    send_sample(32'h0000_00FF, 1'b0);
    send_sample(32'h0000_007F, 1'b0);
    send_sample(32'h0000_0080, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_00FF, 1'b0);
    send_sample(32'h0000_0001, 1'b0);

    // The unused format code mid-stream reads the stored bytes as 32-bit words.
    set_echo(16'd3, GAIN_ONE, FMT_UNUSED);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);

    // Longest delay: a fresh stream only passes through.
    set_echo('1, 17'd32768, FMT_S32);
    send_sample(32'h8000_0001, 1'b1);
    send_sample(32'h7FFF_FFFE, 1'b0);
    send_sample(32'h1234_5678, 1'b0);

    for (int seg = 0; seg < 12; seg++) begin
      case ($urandom_range(4))
        0:       delay = '0;
        1:       delay = 16'd1;
        2, 3:    delay = DELAY_W'($urandom_range(2, 40));
        default: delay = DELAY_W'($urandom_range(41, 130));
      endcase
      case ($urandom_range(3))
        0:       gain = '0;
        1:       gain = GAIN_ONE;
        2:       gain = GAIN_W'($urandom_range(65537, 131071));
        default: gain = GAIN_W'($urandom_range(1, 65535));
      endcase
      case (seg % 4)
        0:       fmt = FMT_U8;
        1:       fmt = FMT_S16;
        2:       fmt = FMT_S32;
        default: fmt = FMT_UNUSED;
      endcase
      set_echo(delay, gain, fmt);
      if (seg == 4) begin
        send_gap_pct = 66;
        recv_gap_pct = 34;
      end else if (seg == 8) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      for (int i = 0; i < 138; i++)
        send_sample(pick_sample(),
                    (i == 0 && $urandom_range(1) == 1) || $urandom_range(49) == 0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("feedforward_echo_delay verification clean");
    else
      $display("feedforward_echo_delay verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("feedforward_echo_delay verification failed");
    $finish;
  end

endmodule

### files.f
hdl/fed_pkg.sv
hdl/fed_ram.sv
hdl/fed_regs.sv
hdl/fed_scale.sv
hdl/feedforward_echo_delay.sv
hdl/fed_checker.sv
bench/fed_echo_checker.sv
bench/feedforward_echo_delay_tb.sv
